@@ design/bm3_pkg.sv @@
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types, register codes and constants of the 3x3 binary morphology
// filter.
// ----------------------------------------------------------------------------
package bm3_pkg;

	// default storage bounds
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	// register reset values
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// field widths
	localparam int PIX_W    = 8;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;

	// pixel values that spread
	localparam logic [PIX_W-1:0] PIX_FULL  = 8'd255;
	localparam logic [PIX_W-1:0] PIX_EMPTY = 8'd0;

	// item kinds
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ERODE_MODE   = 2'd2
	} reg_index_t;

	// input beat
	typedef struct packed {
		logic             op;
		logic [PIX_W-1:0] pixel_in;
	} item_t;

	// output beat
	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_end;
	} result_t;

	// window position flags for one item
	typedef struct packed {
		logic due;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} pos_flags_t;

	// clamp a frame dimension to [2, hi]
	function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] hi);
		logic [31:0] r;
		r = v;
		if (v < 32'd2) begin
			r = 32'd2;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

@@ design/binary_morphology_3x3.sv @@
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// Streaming 3x3 binary dilation / erosion over raster-order 8-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one beat per pixel in raster order (op = pixel), or a drain
//   beat (op = drain) that counts as a zero pixel. After the last pixel of a
//   frame, image_width + 1 drain beats flush the tail of the frame.
//   result channel: one beat per output pixel, frame_end set on the last
//   pixel of the frame. The first image_width + 1 beats of a frame give no
//   result; from then on every beat gives exactly one.
//   cfg channel: register writes, always ready; write only while idle.
// Timing: a taken item is registered in stage one, then its result in the
//   result register. One item per cycle while the result is not stalled:
//   a two-stage pipeline (line buffer read, then window match into the result
//   register) behind one read and one write port per line buffer.
// Reset: counters, window and registers return to their defaults (640 x 480,
//   dilation); the line buffers are not cleared, no pass is run, and items
//   are taken from the first cycle after reset.
// Stall: a stalled result holds in the output register; the pipeline stage
//   before it still moves into a free register, and item_stall rises only
//   when both are full.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 #(
	parameter int MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  bm3_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output bm3_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bm3_pkg::CFG_W-1:0]      cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic                      accept;
	logic                      advance;
	logic                      s1_go;
	logic                      valid_s1;
	logic                      out_valid_q;
	logic [CW-1:0]             addr;
	logic                      erode;
	logic [bm3_pkg::PIX_W-1:0] data;
	logic [bm3_pkg::PIX_W-1:0] older_s1;
	logic [bm3_pkg::PIX_W-1:0] prev_s1;
	logic [bm3_pkg::PIX_W-1:0] data_s1;
	bm3_pkg::pos_flags_t       flags_s1;

	// handshake
	assign s1_go      = !out_valid_q || !result_stall;
	assign advance    = valid_s1 && s1_go;
	assign item_stall = valid_s1 && !s1_go;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign data       = (item.op == bm3_pkg::OP_DRAIN) ? bm3_pkg::PIX_EMPTY : item.pixel_in;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= flags_s1.due;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	bm3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.addr      (addr),
		.flags_s1  (flags_s1),
		.erode     (erode)
	);

	bm3_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.accept   (accept),
		.advance  (advance),
		.addr     (addr),
		.data     (data),
		.older_s1 (older_s1),
		.prev_s1  (prev_s1),
		.data_s1  (data_s1)
	);

	bm3_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.erode    (erode),
		.flags_s1 (flags_s1),
		.older_s1 (older_s1),
		.prev_s1  (prev_s1),
		.data_s1  (data_s1),
		.result_q (result)
	);

	assign result_valid = out_valid_q;

	// a taken item always lands in stage one
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat did not reach stage one");

	// stage one holds its beat while the output register is blocked
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && result_stall |=> valid_s1 && $stable(flags_s1))
		else $error("stage one lost a beat under backpressure");

	// a taken result is not shown again without a new beat behind it
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !valid_s1 |=> !result_valid)
		else $error("result beat repeated");

	// a result only appears from a beat in stage one
	a_due_only: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !valid_s1 |=> !result_valid)
		else $error("result beat without a source");

endmodule

@@ design/bm3_ctrl.sv @@
// ----------------------------------------------------------------------------
// bm3_ctrl
// Configuration registers and the input/output position counters; produces
// the line buffer column and the position flags of each accepted item.
// ----------------------------------------------------------------------------
module bm3_ctrl #(
	parameter int MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [bm3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bm3_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             accept,
	output logic [$clog2(MAX_WIDTH)-1:0]     addr,
	output bm3_pkg::pos_flags_t              flags_s1,
	output logic                             erode
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int XW = WW + 1;
	localparam int YW = HW + 1;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic          erode_q;

	logic [CW-1:0] in_col_q;
	logic [1:0]    in_row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;

	logic [XW-1:0] in_col_inc;
	logic [XW-1:0] out_col_inc;
	logic [YW-1:0] out_row_inc;
	logic          in_wrap;
	bm3_pkg::pos_flags_t flags;

	// configuration writes, stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(bm3_pkg::clamp_dim(32'(bm3_pkg::WIDTH_RESET), 32'(MAX_WIDTH)));
			height_q <= HW'(bm3_pkg::clamp_dim(32'(bm3_pkg::HEIGHT_RESET), 32'(MAX_HEIGHT)));
			erode_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bm3_pkg::REG_IMAGE_WIDTH: begin
					width_q <= WW'(bm3_pkg::clamp_dim(
						32'(cfg_data[bm3_pkg::WIDTH_REG_W-1:0]), 32'(MAX_WIDTH)));
				end
				bm3_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= HW'(bm3_pkg::clamp_dim(
						32'(cfg_data[bm3_pkg::HEIGHT_REG_W-1:0]), 32'(MAX_HEIGHT)));
				end
				bm3_pkg::REG_ERODE_MODE: begin
					erode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// position compares
	always_comb begin
		in_col_inc  = XW'(in_col_q) + XW'(1);
		out_col_inc = XW'(out_col_q) + XW'(1);
		out_row_inc = YW'(out_row_q) + YW'(1);
		in_wrap     = in_col_inc >= XW'(width_q);

		flags.due    = (in_row_q == 2'd2) || (in_row_q == 2'd1 && in_col_q != '0);
		flags.top    = out_row_q != '0;
		flags.bottom = out_row_inc < YW'(height_q);
		flags.left   = out_col_q != '0;
		flags.right  = out_col_inc < XW'(width_q);
		flags.last   = !flags.bottom && !flags.right;
	end

	// counters advance only on accepted beats; only the row fill state of
	// the input side matters, so its row count saturates at two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (flags.due && flags.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					if (in_row_q != 2'd2) begin
						in_row_q <= in_row_q + 2'd1;
					end
				end else begin
					in_col_q <= CW'(in_col_inc);
				end
				if (flags.due) begin
					if (!flags.right) begin
						out_col_q <= '0;
						out_row_q <= RW'(out_row_inc);
					end else begin
						out_col_q <= CW'(out_col_inc);
					end
				end
			end
		end
	end

	// flags follow the beat into stage one
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
		end
	end

	assign addr  = in_col_q;
	assign erode = erode_q;

endmodule

@@ design/bm3_line_buf.sv @@
// ----------------------------------------------------------------------------
// bm3_line_buf
// Two line buffers in block memory: the row above and the row two above the
// incoming pixel, read at the input column with registered read data.
// ----------------------------------------------------------------------------
module bm3_line_buf #(
	parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            accept,
	input  logic                            advance,
	input  logic [$clog2(MAX_WIDTH)-1:0]    addr,
	input  logic [bm3_pkg::PIX_W-1:0]       data,
	output logic [bm3_pkg::PIX_W-1:0]       older_s1,
	output logic [bm3_pkg::PIX_W-1:0]       prev_s1,
	output logic [bm3_pkg::PIX_W-1:0]       data_s1
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [bm3_pkg::PIX_W-1:0] row_a [MAX_WIDTH];
	logic [bm3_pkg::PIX_W-1:0] row_b [MAX_WIDTH];
	logic [CW-1:0]             addr_s1;

	// row above: read first, then overwrite with the new pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_s1      <= row_a[addr];
			row_a[addr]  <= data;
			data_s1      <= data;
			addr_s1      <= addr;
		end
	end

	// row two above: read at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			older_s1 <= row_b[addr];
		end
	end

	// row two above: takes the retired row-above pixel when stage one moves on
	always_ff @(posedge clk) begin
		if (advance) begin
			row_b[addr_s1] <= prev_s1;
		end
	end

endmodule

@@ design/bm3_window.sv @@
// ----------------------------------------------------------------------------
// bm3_window
// 3x3 window columns and the border-masked match that forms the output pixel,
// with the result register.
// ----------------------------------------------------------------------------
module bm3_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       erode,
	input  bm3_pkg::pos_flags_t        flags_s1,
	input  logic [bm3_pkg::PIX_W-1:0]  older_s1,
	input  logic [bm3_pkg::PIX_W-1:0]  prev_s1,
	input  logic [bm3_pkg::PIX_W-1:0]  data_s1,
	output bm3_pkg::result_t           result_q
);

	logic [bm3_pkg::PIX_W-1:0] mid_q   [3];
	logic [bm3_pkg::PIX_W-1:0] right_q [3];
	logic [bm3_pkg::PIX_W-1:0] col_new [3];
	logic [bm3_pkg::PIX_W-1:0] target;
	logic [2:0]                row_en;
	logic                      hit;

	assign col_new[0] = older_s1;
	assign col_new[1] = prev_s1;
	assign col_new[2] = data_s1;

	// masked compare over the nine window taps
	always_comb begin
		target = erode ? bm3_pkg::PIX_EMPTY : bm3_pkg::PIX_FULL;
		row_en = {flags_s1.bottom, 1'b1, flags_s1.top};
		hit    = 1'b0;
		for (int r = 0; r < 3; r++) begin
			if (row_en[r]) begin
				if (flags_s1.left && mid_q[r] == target) begin
					hit = 1'b1;
				end
				if (right_q[r] == target) begin
					hit = 1'b1;
				end
				if (flags_s1.right && col_new[r] == target) begin
					hit = 1'b1;
				end
			end
		end
	end

	// window shifts by one column per retired beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				mid_q[r]   <= '0;
				right_q[r] <= '0;
			end
		end else if (advance) begin
			for (int r = 0; r < 3; r++) begin
				mid_q[r]   <= right_q[r];
				right_q[r] <= col_new[r];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && flags_s1.due) begin
			result_q.pixel_out <= hit ? target : right_q[1];
			result_q.frame_end <= flags_s1.last;
		end
	end

endmodule
